/* design/atan2_rational_approx_assert.svh */
// Assertion macros shared by the arctangent unit.
`ifndef ATAN2_RATIONAL_APPROX_ASSERT_SVH
`define ATAN2_RATIONAL_APPROX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ata_pkg.sv */
// Shared types, constants and arithmetic helpers of the arctangent unit.
package ata_pkg;

	localparam int QF                  = 30;
	localparam int STEPS               = QF + 1;
	localparam int OPERAND_FRAC        = 16;
	localparam int DEF_OPERAND_WIDTH   = 32;
	localparam int DEF_ANGLE_FRAC_BITS = 28;
	localparam int ANGLE_W             = 32;
	localparam int QUEUE_DEPTH         = 4;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	localparam logic [30:0] Q_ONE    = 31'h4000_0000;
	localparam logic [30:0] C_A0     = 31'd1073597943;
	localparam logic [30:0] C_A1_MAG = 31'd354656388;
	localparam logic [30:0] C_B1     = 31'd193424926;
	localparam logic [30:0] C_B2_MAG = 31'd13581975;

	typedef enum logic {
		CMD_ATAN2 = 1'b0,
		CMD_ATAN  = 1'b1
	} ata_cmd_t;

	typedef struct packed {
		logic zero;
		logic nx;
		logic ny;
		logic swap;
	} ata_flags_t;

	// Unsigned Q30 product rounded half up.
	function automatic logic [31:0] umulq(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = 62'(a) * 62'(b) + (62'd1 << (QF - 1));
		return p[61:30];
	endfunction

endpackage

/* design/ata_in_if.sv */
// Input channel: command and two signed operands.
interface ata_in_if #(parameter int OW = ata_pkg::DEF_OPERAND_WIDTH);
	logic               valid;
	logic               ready;
	ata_pkg::ata_cmd_t  command;
	logic signed [OW-1:0] y_value;
	logic signed [OW-1:0] x_value;

	modport source(output valid, command, y_value, x_value, input ready);
	modport sink(input valid, command, y_value, x_value, output ready);
endinterface

/* design/ata_out_if.sv */
// Output channel: angle and undefined flag.
interface ata_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [ata_pkg::ANGLE_W-1:0] angle;
	logic                              undefined;

	modport source(output valid, angle, undefined, input ready);
	modport sink(input valid, angle, undefined, output ready);
endinterface

/* design/ata_front.sv */
// Front end: takes operands, forms magnitudes and picks the octant branch.
module ata_front #(
	parameter int OW = ata_pkg::DEF_OPERAND_WIDTH,
	parameter int MW = ata_pkg::DEF_OPERAND_WIDTH
) (
	ata_in_if.sink                 in_ch,
	input  logic                   full,
	output logic                   push,
	output ata_pkg::ata_flags_t    flags,
	output logic [MW-1:0]          num,
	output logic [MW-1:0]          den
);
	import ata_pkg::*;

	logic [OW-1:0] yu;
	logic [OW-1:0] xu;
	logic [MW-1:0] my;
	logic [MW-1:0] mx;
	logic          ny;
	logic          nx;

	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;

	always_comb begin
		yu = in_ch.y_value;
		xu = in_ch.x_value;
		ny = yu[OW-1];
		my = MW'(ny ? (~yu + OW'(1)) : yu);
		if (in_ch.command == CMD_ATAN) begin
			nx = 1'b0;
			mx = MW'(1) << OPERAND_FRAC;
		end else begin
			nx = xu[OW-1];
			mx = MW'(nx ? (~xu + OW'(1)) : xu);
		end
		flags.zero = (mx == '0) && (my == '0);
		flags.nx   = nx;
		flags.ny   = ny;
		// Equal magnitudes go to the steep branch, as does |y| above |x|.
		flags.swap = !(mx > my);
		num = flags.swap ? mx : my;
		den = flags.swap ? my : mx;
	end
endmodule

/* design/ata_queue.sv */
// Short FIFO between the front end and the arithmetic back end.
module ata_queue #(
	parameter int W     = 8,
	parameter int DEPTH = ata_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         nonempty
);
	import ata_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   count_q;

	assign full     = count_q == (AW+1)'(DEPTH);
	assign nonempty = count_q != '0;
	assign dout     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop)  rd_q <= rd_q + AW'(1);
			if (push && !pop)      count_q <= count_q + (AW+1)'(1);
			else if (pop && !push) count_q <= count_q - (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

`include "atan2_rational_approx_assert.svh"
	`ATA_ASSERT_SAME(a_count_bound, 1'b1, count_q <= (AW+1)'(DEPTH), "queue count overflow")
	`ATA_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + (AW+1)'(1), "queue count did not rise")
	`ATA_ASSERT_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - (AW+1)'(1), "queue count did not fall")
endmodule

/* design/ata_div.sv */
// Pipelined restoring divider giving floor(num * 2^30 / den) for num <= den.
module ata_div #(
	parameter int W  = 32,
	parameter int TW = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  logic [W-1:0]              num,
	input  logic [W-1:0]              den,
	input  logic [TW-1:0]             tag,
	output logic                      out_v,
	output logic [ata_pkg::STEPS-1:0] q,
	output logic [TW-1:0]             tag_o
);
	import ata_pkg::*;

	logic [W:0]       rem_s [STEPS];
	logic [STEPS-1:0] quo_s [STEPS];
	logic [W-1:0]     den_s [STEPS];
	logic [TW-1:0]    tag_s [STEPS];
	logic             v_s   [STEPS];

	logic [W:0]       rem_n [STEPS];
	logic [STEPS-1:0] quo_n [STEPS];

	// The first step compares without shifting, every later step shifts in a zero.
	always_comb begin
		logic [W:0]       rin;
		logic [STEPS-1:0] qin;
		rin = {1'b0, num};
		if (rin >= {1'b0, den}) begin
			rem_n[0] = rin - {1'b0, den};
			quo_n[0] = STEPS'(1);
		end else begin
			rem_n[0] = rin;
			quo_n[0] = '0;
		end
		for (int k = 1; k < STEPS; k++) begin
			rin = {rem_s[k-1][W-1:0], 1'b0};
			qin = {quo_s[k-1][STEPS-2:0], 1'b0};
			if (rin >= {1'b0, den_s[k-1]}) begin
				rem_n[k] = rin - {1'b0, den_s[k-1]};
				quo_n[k] = qin | STEPS'(1);
			end else begin
				rem_n[k] = rin;
				quo_n[k] = qin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEPS; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
			for (int k = 1; k < STEPS; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			tag_s[0] <= tag;
			for (int k = 1; k < STEPS; k++) begin
				den_s[k] <= den_s[k-1];
				tag_s[k] <= tag_s[k-1];
			end
			for (int k = 0; k < STEPS; k++) begin
				rem_s[k] <= rem_n[k];
				quo_s[k] <= quo_n[k];
			end
		end
	end

	assign out_v = v_s[STEPS-1];
	assign q     = quo_s[STEPS-1];
	assign tag_o = tag_s[STEPS-1];
endmodule

/* design/ata_back.sv */
// Back end: ratio divide, rational fit, fit divide and quadrant correction.
module ata_back #(
	parameter int MW = ata_pkg::DEF_OPERAND_WIDTH,
	parameter int FB = ata_pkg::DEF_ANGLE_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fq_valid,
	input  ata_pkg::ata_flags_t fq_flags,
	input  logic [MW-1:0]       fq_num,
	input  logic [MW-1:0]       fq_den,
	output logic                fq_pop,
	ata_out_if.source           out_ch
);
	import ata_pkg::*;

	localparam int SW  = (FB + 3 > 33) ? FB + 3 : 33;
	localparam int SHR = (FB < QF) ? QF - FB : 1;
	localparam int SHL = (FB > QF) ? FB - QF : 0;
	localparam logic [SW-1:0] PI_FULL =
		SW'((PI_Q60 + (64'd1 << (60 - FB - 1))) >> (60 - FB));
	localparam logic [SW-1:0] PI_HALF =
		SW'((PI_Q60 + (64'd1 << (61 - FB - 1))) >> (61 - FB));

	logic en;
	logic out_v_q;

	logic             d1_v;
	logic [STEPS-1:0] d1_q;
	logic [3:0]       d1_tag;

	logic             v_s1, v_s2, v_s3, v_s4;
	ata_flags_t       f_s1, f_s2, f_s3, f_s4;
	logic [30:0]      r_s1, r_s2, r_s3;
	logic [30:0]      r2_s1, r4_s2, pa1_s2, pb1_s2;
	logic [30:0]      num_s3, denp_s3, pb2_s3;
	logic [30:0]      p_s4, den_s4;
	logic [31:0]      r2_full, r4_full, pa1_full, pb1_full, pb2_full, p_full;

	logic             d2_v;
	logic [STEPS-1:0] d2_q;
	logic [3:0]       d2_tag;
	ata_flags_t       f_d2;

	logic [SW-1:0]    qx, c, m, s;
	logic [ANGLE_W-1:0] angle_n;
	logic [ANGLE_W-1:0] angle_q;
	logic             undef_q;

	// The whole back end moves together whenever the output register can take a value.
	assign en     = !out_v_q || out_ch.ready;
	assign fq_pop = en && fq_valid;

	ata_div #(.W(MW), .TW(4)) u_div_ratio (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.in_v  (fq_valid),
		.num   (fq_num),
		.den   (fq_den),
		.tag   (fq_flags),
		.out_v (d1_v),
		.q     (d1_q),
		.tag_o (d1_tag)
	);

	assign r2_full  = umulq(d1_q, d1_q);
	assign r4_full  = umulq(r2_s1, r2_s1);
	assign pa1_full = umulq(C_A1_MAG, r2_s1);
	assign pb1_full = umulq(C_B1, r2_s1);
	assign pb2_full = umulq(C_B2_MAG, r4_s2);
	assign p_full   = umulq(r_s3, num_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= d1_v;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			out_v_q <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1    <= ata_flags_t'(d1_tag);
			r_s1    <= d1_q;
			r2_s1   <= r2_full[30:0];
			f_s2    <= f_s1;
			r_s2    <= r_s1;
			r4_s2   <= r4_full[30:0];
			pa1_s2  <= pa1_full[30:0];
			pb1_s2  <= pb1_full[30:0];
			f_s3    <= f_s2;
			r_s3    <= r_s2;
			num_s3  <= C_A0 - pa1_s2;
			denp_s3 <= Q_ONE + pb1_s2;
			pb2_s3  <= pb2_full[30:0];
			f_s4    <= f_s3;
			p_s4    <= p_full[30:0];
			den_s4  <= denp_s3 - pb2_s3;
			angle_q <= angle_n;
			undef_q <= f_d2.zero;
		end
	end

	ata_div #(.W(31), .TW(4)) u_div_fit (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.in_v  (v_s4),
		.num   (p_s4),
		.den   (den_s4),
		.tag   (f_s4),
		.out_v (d2_v),
		.q     (d2_q),
		.tag_o (d2_tag)
	);

	assign f_d2 = ata_flags_t'(d2_tag);

	always_comb begin
		qx = SW'(d2_q);
		if (FB < QF) c = (qx + (SW'(1) << (SHR - 1))) >> SHR;
		else         c = qx << SHL;
		if (f_d2.swap) m = f_d2.nx ? PI_HALF + c : PI_HALF - c;
		else           m = f_d2.nx ? PI_FULL - c : c;
		s = f_d2.ny ? (~m + SW'(1)) : m;
		angle_n = f_d2.zero ? '0 : s[ANGLE_W-1:0];
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.angle     = angle_q;
	assign out_ch.undefined = undef_q;
endmodule

/* design/atan2_rational_approx.sv */
// Top level of the fixed-point arctangent unit.
//
//  channel  | role   | payload                                | transfer when
//  ---------+--------+----------------------------------------+---------------
//  in_ch    | sink   | command, y_value, x_value (Q16.16)     | valid && ready
//  out_ch   | source | angle (Q3.28 radians), undefined       | valid && ready
//
// One item enters per cycle while the queue is not full, and one result leaves per cycle
// when the output is taken. Items pass through two 31-stage restoring dividers and four
// multiply stages, with the output register last, after any time spent in the queue.
// Reset clears the queue pointers and every stage valid; no clearing pass is needed.
// An output stall freezes the back end; the front keeps taking items until the
// four-entry queue is full, and then in_ch.ready drops.
module atan2_rational_approx #(
	parameter int OPERAND_WIDTH   = ata_pkg::DEF_OPERAND_WIDTH,
	parameter int ANGLE_FRAC_BITS = ata_pkg::DEF_ANGLE_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	ata_in_if.sink    in_ch,
	ata_out_if.source out_ch
);
	import ata_pkg::*;

	// Magnitudes need room for the constant 1.0 used in atan mode.
	localparam int MW = (OPERAND_WIDTH > OPERAND_FRAC + 1) ? OPERAND_WIDTH : OPERAND_FRAC + 1;
	localparam int QW = 4 + 2 * MW;

	logic          push;
	logic          full;
	logic          pop;
	logic          nonempty;
	ata_flags_t    fr_flags;
	logic [MW-1:0] fr_num;
	logic [MW-1:0] fr_den;
	logic [QW-1:0] q_dout;

	// The front classifies each transfer straight into the queue.
	ata_front #(.OW(OPERAND_WIDTH), .MW(MW)) u_front (
		.in_ch(in_ch),
		.full (full),
		.push (push),
		.flags(fr_flags),
		.num  (fr_num),
		.den  (fr_den)
	);

	ata_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.din     ({fr_flags, fr_num, fr_den}),
		.full    (full),
		.pop     (pop),
		.dout    (q_dout),
		.nonempty(nonempty)
	);

	// The back end pops whenever it advances and the queue holds an entry.
	ata_back #(.MW(MW), .FB(ANGLE_FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.fq_valid(nonempty),
		.fq_flags(ata_flags_t'(q_dout[QW-1 -: 4])),
		.fq_num  (q_dout[2*MW-1 -: MW]),
		.fq_den  (q_dout[MW-1:0]),
		.fq_pop  (pop),
		.out_ch  (out_ch)
	);
endmodule
